/* sv/sample_playback_voice_top_assert.svh */
// ----------------------------------------------------------------------------
// Sampler voice assertion macros
// Concurrent assertion shorthands that report through $error.
// ----------------------------------------------------------------------------
`ifndef SAMPLE_PLAYBACK_VOICE_TOP_ASSERT_SVH
`define SAMPLE_PLAYBACK_VOICE_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define SPV_ASSERT_IMPLIES(label, c, r, ante, cons, msg) \
  label: assert property (@(posedge c) disable iff (r) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SPV_ASSERT_NEXT(label, c, r, ante, cons, msg) \
  label: assert property (@(posedge c) disable iff (r) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/spv_pkg.sv */
// ----------------------------------------------------------------------------
// Sampler voice package
// Shared widths, operation and register codes, and the arithmetic unit control.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package spv_pkg;

  localparam int STORE_DEPTH_DEFAULT = 65536;
  localparam int SAMPLE_BITS_DEFAULT = 16;

  // Field widths fixed by the item and register formats
  localparam int OP_W      = 3;
  localparam int ADDR_W    = 16;
  localparam int BEATS_W   = 16;
  localparam int TEMPO_W   = 16;
  localparam int LEN_W     = 17;
  localparam int FRAC_W    = 17;
  localparam int GAIN_W    = 16;
  localparam int RATE_W    = 18;
  localparam int COUNT_W   = 31;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 18;

  // Operation codes
  localparam logic [OP_W-1:0] OP_LOAD    = 3'd0;
  localparam logic [OP_W-1:0] OP_CLEAR   = 3'd1;
  localparam logic [OP_W-1:0] OP_TRIGGER = 3'd2;
  localparam logic [OP_W-1:0] OP_STOP    = 3'd3;
  localparam logic [OP_W-1:0] OP_TICK    = 3'd4;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_START_FRACTION = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_END_FRACTION   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN           = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_LOOP_MODE      = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_RATE    = 3'd4;

  localparam logic [FRAC_W-1:0] FRAC_ONE   = 17'd65536;
  localparam logic [GAIN_W-1:0] GAIN_ONE   = 16'd16384;
  localparam logic [GAIN_W-1:0] GAIN_MAX   = 16'd32768;
  localparam logic [RATE_W-1:0] RATE_RESET = 18'd48000;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 31'h7FFF_FFFF;

  localparam int FRAC_SHIFT = 16;
  localparam int GAIN_SHIFT = 14;

  // Shared multiplier and divider geometry
  localparam int BEATS15_W = 20;
  localparam int MUL_B_W   = 19;
  localparam int NUM_W     = 38;
  localparam int DIV_STEPS = NUM_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  function automatic int mul_a_width(input int sample_bits);
    return ((sample_bits > BEATS15_W) ? sample_bits : BEATS15_W) + 1;
  endfunction

  typedef struct packed {
    logic mul_en;
    logic div_load;
    logic div_step;
  } alu_ctl_t;

endpackage

/* sv/spv_if.sv */
// ----------------------------------------------------------------------------
// Sampler voice channels
// Item, result and register write channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface spv_item_if #(
  parameter int SAMPLE_BITS = spv_pkg::SAMPLE_BITS_DEFAULT
);
  logic                              valid;
  logic                              ready;
  logic [spv_pkg::OP_W-1:0]          operation;
  logic [spv_pkg::ADDR_W-1:0]        frame_address;
  logic signed [SAMPLE_BITS-1:0]     sample_value;
  logic                              last_frame;
  logic [spv_pkg::BEATS_W-1:0]       beat_duration;
  logic [spv_pkg::TEMPO_W-1:0]       tempo;

  modport source (
    output valid, operation, frame_address, sample_value, last_frame, beat_duration, tempo,
    input  ready
  );
  modport sink (
    input  valid, operation, frame_address, sample_value, last_frame, beat_duration, tempo,
    output ready
  );
endinterface

interface spv_result_if #(
  parameter int SAMPLE_BITS = spv_pkg::SAMPLE_BITS_DEFAULT
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] audio_out;
  logic                          playing;
  logic [spv_pkg::LEN_W-1:0]     playhead;

  modport source (output valid, audio_out, playing, playhead, input ready);
  modport sink   (input  valid, audio_out, playing, playhead, output ready);
endinterface

interface spv_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [spv_pkg::CFG_INDEX_W-1:0] index;
  logic [spv_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input  valid, index, data, output ready);
endinterface

/* sv/spv_ram.sv */
// ----------------------------------------------------------------------------
// Sampler voice RAM
// Generic one-write, one-read memory with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spv_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/spv_alu.sv */
// ----------------------------------------------------------------------------
// Sampler voice arithmetic unit
// Registered signed multiplier and a restoring divider, one bit per cycle while stepped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spv_alu #(
  parameter int SAMPLE_BITS = spv_pkg::SAMPLE_BITS_DEFAULT,
  localparam int A_W = spv_pkg::mul_a_width(SAMPLE_BITS),
  localparam int P_W = A_W + spv_pkg::MUL_B_W
) (
  input  logic                            clk,
  input  logic                            rst,
  input  spv_pkg::alu_ctl_t               ctl,
  input  logic signed [A_W-1:0]           mul_a,
  input  logic signed [spv_pkg::MUL_B_W-1:0] mul_b,
  output logic signed [P_W-1:0]           product,
  input  logic [spv_pkg::NUM_W-1:0]       dividend,
  input  logic [spv_pkg::TEMPO_W-1:0]     divisor,
  output logic [spv_pkg::NUM_W-1:0]       quotient,
  output logic                            div_done
);

  localparam int NW = spv_pkg::NUM_W;
  localparam int DW = spv_pkg::TEMPO_W;

  logic [DW-1:0]                 rem;
  logic [DW-1:0]                 divisor_r;
  logic [spv_pkg::DIV_CNT_W-1:0] count;
  logic [DW:0]                   rem_sh;
  logic [DW:0]                   diff;
  logic                          take;

  assign rem_sh   = {rem, quotient[NW-1]};
  assign diff     = rem_sh - {1'b0, divisor_r};
  assign take     = rem_sh >= {1'b0, divisor_r};
  assign div_done = (count == '0);

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      product <= mul_a * mul_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.div_load) begin
      count <= spv_pkg::DIV_CNT_W'(spv_pkg::DIV_STEPS);
    end else if (ctl.div_step && !div_done) begin
      count <= count - 1'b1;
    end
  end

  // Shift one quotient bit in per step; the remainder stays below a nonzero divisor
  always_ff @(posedge clk) begin
    if (ctl.div_load) begin
      quotient  <= dividend;
      rem       <= '0;
      divisor_r <= divisor;
    end else if (ctl.div_step && !div_done) begin
      rem      <= take ? diff[DW-1:0] : rem_sh[DW-1:0];
      quotient <= {quotient[NW-2:0], take};
    end
  end

endmodule

/* sv/sample_playback_voice_top.sv */
// ----------------------------------------------------------------------------
// Sampler voice
// One whole-frame playback voice: sample store, trigger countdown and gain.
// ----------------------------------------------------------------------------
//
// Channel  Dir  Handshake      Transaction
// item     in   valid/ready    load, clear, trigger, stop or tick command
// result   out  valid/ready    audio_out, playing, playhead after the command
// cfg      in   valid/ready    register write (index, data), always ready
//
// Ready is high only in the idle state. Load, clear, stop, unused codes, a
// trigger with no sample and a tick with nothing to play go from decode
// straight to the final state; a playing tick adds a sample store read and
// three passes through the shared multiplier; an armed trigger waits on the
// 38-step restoring divider that forms the countdown.
// Reset (rst, synchronous) clears control state and loads register defaults;
// the sample store is not cleared and holds garbage until written.
// A stalled result sits in the output register; the voice keeps working on
// the next command and waits in the final state only if that register is full.
//
`timescale 1ns / 1ps
`include "sample_playback_voice_top_assert.svh"

module sample_playback_voice_top #(
  parameter int STORE_DEPTH = spv_pkg::STORE_DEPTH_DEFAULT,
  parameter int SAMPLE_BITS = spv_pkg::SAMPLE_BITS_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  spv_item_if.sink      item,
  spv_result_if.source  result,
  spv_cfg_if.sink       cfg
);

  localparam int AW    = $clog2(STORE_DEPTH);
  localparam int IW    = (AW > spv_pkg::LEN_W) ? AW : spv_pkg::LEN_W;
  localparam int A_W   = spv_pkg::mul_a_width(SAMPLE_BITS);
  localparam int B_W   = spv_pkg::MUL_B_W;
  localparam int P_W   = A_W + B_W;
  localparam int LEN_W = spv_pkg::LEN_W;
  localparam int CNT_W = spv_pkg::COUNT_W;
  localparam int NW    = spv_pkg::NUM_W;

  localparam logic signed [P_W-1:0] SAT_HI = P_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [P_W-1:0] SAT_LO = ~SAT_HI;
  localparam logic signed [P_W-1:0] ROUND_HALF = P_W'(64'sd1 <<< (spv_pkg::GAIN_SHIFT - 1));

  // Sequencer states
  localparam logic [3:0] S_IDLE       = 4'd0;
  localparam logic [3:0] S_DECODE     = 4'd1;
  localparam logic [3:0] S_TRIG_START = 4'd2;
  localparam logic [3:0] S_TRIG_CAP   = 4'd3;
  localparam logic [3:0] S_TRIG_DIV   = 4'd4;
  localparam logic [3:0] S_TICK_RE    = 4'd5;
  localparam logic [3:0] S_TICK_GAIN  = 4'd6;
  localparam logic [3:0] S_TICK_END   = 4'd7;
  localparam logic [3:0] S_DONE       = 4'd8;

  logic [3:0] state;

  // Captured command
  logic [spv_pkg::OP_W-1:0]     op_r;
  logic [spv_pkg::ADDR_W-1:0]   addr_r;
  logic signed [SAMPLE_BITS-1:0] value_r;
  logic                         last_r;
  logic [spv_pkg::BEATS_W-1:0]  beats_r;
  logic [spv_pkg::TEMPO_W-1:0]  tempo_r;

  // Registers
  logic [spv_pkg::FRAC_W-1:0] start_fraction;
  logic [spv_pkg::FRAC_W-1:0] end_fraction;
  logic [spv_pkg::GAIN_W-1:0] gain;
  logic                       loop_mode;
  logic [spv_pkg::RATE_W-1:0] sample_rate;

  // Voice state
  logic [LEN_W-1:0] frame_count;
  logic [LEN_W-1:0] playhead_r;
  logic [CNT_W-1:0] samples_left;
  logic             is_playing;

  // Working values
  logic [LEN_W-1:0]              rs_r;
  logic [LEN_W-1:0]              re_r;
  logic signed [SAMPLE_BITS-1:0] sample_r;
  logic signed [SAMPLE_BITS-1:0] audio_r;

  // Output register
  logic                          out_valid;
  logic signed [SAMPLE_BITS-1:0] out_audio;
  logic                          out_playing;
  logic [LEN_W-1:0]              out_playhead;

  // Shared unit hookup
  spv_pkg::alu_ctl_t        ctl;
  logic signed [A_W-1:0]    mul_a;
  logic signed [B_W-1:0]    mul_b;
  logic signed [P_W-1:0]    product;
  logic [NW-1:0]            quotient;
  logic                     div_done;

  logic                          ram_we;
  logic [SAMPLE_BITS-1:0]        ram_rdata;
  logic [IW-1:0]                 waddr_ext;
  logic [IW-1:0]                 raddr_ext;

  logic [spv_pkg::FRAC_W-1:0]    start_c;
  logic [spv_pkg::FRAC_W-1:0]    end_c;
  logic [spv_pkg::GAIN_W-1:0]    gain_c;
  logic [spv_pkg::BEATS15_W-1:0] beats15;
  logic                          addr_ok;
  logic                          head_ok;
  logic [LEN_W-1:0]              region_pt;
  logic signed [P_W-1:0]         rounded;
  logic signed [P_W-1:0]         scaled;
  logic signed [SAMPLE_BITS-1:0] gain_sat;
  logic [LEN_W:0]                re_eff;
  logic [LEN_W:0]                head_inc;
  logic                          at_end;
  logic [CNT_W-1:0]              count_sat;

  // Clamp fractions to 1.0 and gain to 2.0
  assign start_c = (start_fraction > spv_pkg::FRAC_ONE) ? spv_pkg::FRAC_ONE : start_fraction;
  assign end_c   = (end_fraction > spv_pkg::FRAC_ONE) ? spv_pkg::FRAC_ONE : end_fraction;
  assign gain_c  = (gain > spv_pkg::GAIN_MAX) ? spv_pkg::GAIN_MAX : gain;

  // beats * 15 as a shift and subtract; 60 / 4 folds the Q8.8 and Q10.6 scaling
  assign beats15 = spv_pkg::BEATS15_W'({beats_r, 4'b0000}) - spv_pkg::BEATS15_W'(beats_r);

  assign waddr_ext = IW'(addr_r);
  assign raddr_ext = IW'(playhead_r);
  assign addr_ok   = (IW + 1)'(addr_r) < (IW + 1)'(STORE_DEPTH);
  assign head_ok   = (playhead_r < frame_count)
                  && ((IW + 1)'(playhead_r) < (IW + 1)'(STORE_DEPTH));

  // floor(frame_count * fraction / 65536) from the product register
  assign region_pt = product[spv_pkg::FRAC_SHIFT +: LEN_W];

  // Round half up, then saturate to the sample range
  assign rounded  = product + ROUND_HALF;
  assign scaled   = rounded >>> spv_pkg::GAIN_SHIFT;
  assign gain_sat = (scaled > SAT_HI) ? SAT_HI[SAMPLE_BITS-1:0]
                  : (scaled < SAT_LO) ? SAT_LO[SAMPLE_BITS-1:0]
                  : scaled[SAMPLE_BITS-1:0];

  // An empty region still plays one frame
  assign re_eff   = (re_r <= rs_r) ? ({1'b0, rs_r} + 1'b1) : {1'b0, re_r};
  assign head_inc = {1'b0, playhead_r} + 1'b1;
  assign at_end   = head_inc >= re_eff;

  assign count_sat = (quotient[NW-1:CNT_W] != '0) ? spv_pkg::COUNT_MAX : quotient[CNT_W-1:0];

  // Operand select for the shared multiplier and divider
  always_comb begin
    ctl    = '0;
    mul_a  = '0;
    mul_b  = '0;
    ram_we = 1'b0;
    unique case (state)
      S_DECODE: begin
        ram_we = (op_r == spv_pkg::OP_LOAD) && addr_ok;
        if (op_r == spv_pkg::OP_TRIGGER) begin
          ctl.mul_en = 1'b1;
          mul_a      = A_W'(beats15);
          mul_b      = B_W'(sample_rate);
        end else if (op_r == spv_pkg::OP_TICK) begin
          ctl.mul_en = 1'b1;
          mul_a      = A_W'(frame_count);
          mul_b      = B_W'(start_c);
        end
      end
      S_TRIG_START: begin
        ctl.div_load = 1'b1;
        ctl.mul_en   = 1'b1;
        mul_a        = A_W'(frame_count);
        mul_b        = B_W'(start_c);
      end
      S_TRIG_CAP: begin
        ctl.div_step = 1'b1;
      end
      S_TRIG_DIV: begin
        ctl.div_step = !div_done;
      end
      S_TICK_RE: begin
        ctl.mul_en = 1'b1;
        mul_a      = A_W'(frame_count);
        mul_b      = B_W'(end_c);
      end
      S_TICK_GAIN: begin
        ctl.mul_en = 1'b1;
        mul_a      = A_W'(sample_r);
        mul_b      = B_W'(gain_c);
      end
      default: begin
      end
    endcase
  end

  spv_alu #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_alu (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .mul_a    (mul_a),
    .mul_b    (mul_b),
    .product  (product),
    .dividend (product[NW-1:0]),
    .divisor  (tempo_r),
    .quotient (quotient),
    .div_done (div_done)
  );

  spv_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr_ext[AW-1:0]),
    .wdata (value_r),
    .raddr (raddr_ext[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign item.ready = (state == S_IDLE);
  assign cfg.ready  = 1'b1;

  assign result.valid     = out_valid;
  assign result.audio_out = out_audio;
  assign result.playing   = out_playing;
  assign result.playhead  = out_playhead;

  // Register writes; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      start_fraction <= '0;
      end_fraction   <= spv_pkg::FRAC_ONE;
      gain           <= spv_pkg::GAIN_ONE;
      loop_mode      <= 1'b0;
      sample_rate    <= spv_pkg::RATE_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        spv_pkg::REG_START_FRACTION: start_fraction <= cfg.data[spv_pkg::FRAC_W-1:0];
        spv_pkg::REG_END_FRACTION:   end_fraction   <= cfg.data[spv_pkg::FRAC_W-1:0];
        spv_pkg::REG_GAIN:           gain           <= cfg.data[spv_pkg::GAIN_W-1:0];
        spv_pkg::REG_LOOP_MODE:      loop_mode      <= cfg.data[0];
        spv_pkg::REG_SAMPLE_RATE:    sample_rate    <= cfg.data[spv_pkg::RATE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Capture the command on acceptance
  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      op_r    <= item.operation;
      addr_r  <= item.frame_address;
      value_r <= item.sample_value;
      last_r  <= item.last_frame;
      beats_r <= item.beat_duration;
      tempo_r <= item.tempo;
    end
  end

  // Sequencer and voice state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      frame_count  <= '0;
      playhead_r   <= '0;
      samples_left <= '0;
      is_playing   <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (item.valid) begin
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          unique case (op_r)
            spv_pkg::OP_LOAD: begin
              state <= S_DONE;
              if (addr_ok && last_r) begin
                frame_count <= LEN_W'(addr_r) + 1'b1;
              end
            end
            spv_pkg::OP_CLEAR: begin
              state       <= S_DONE;
              frame_count <= '0;
              is_playing  <= 1'b0;
            end
            spv_pkg::OP_TRIGGER: begin
              if (frame_count != '0) begin
                state <= S_TRIG_START;
              end else begin
                state <= S_DONE;
              end
            end
            spv_pkg::OP_STOP: begin
              state        <= S_DONE;
              is_playing   <= 1'b0;
              samples_left <= '0;
            end
            spv_pkg::OP_TICK: begin
              // Idle or empty: nothing changes. Countdown spent: stop silently.
              if (frame_count != '0 && is_playing) begin
                if (samples_left == '0) begin
                  is_playing <= 1'b0;
                  state      <= S_DONE;
                end else begin
                  state <= S_TICK_RE;
                end
              end else begin
                state <= S_DONE;
              end
            end
            default: begin
              state <= S_DONE;
            end
          endcase
        end
        S_TRIG_START: begin
          state <= S_TRIG_CAP;
        end
        S_TRIG_CAP: begin
          state <= S_TRIG_DIV;
        end
        S_TRIG_DIV: begin
          if (div_done) begin
            playhead_r   <= rs_r;
            samples_left <= count_sat;
            is_playing   <= 1'b1;
            state        <= S_DONE;
          end
        end
        S_TICK_RE: begin
          state <= S_TICK_GAIN;
        end
        S_TICK_GAIN: begin
          state <= S_TICK_END;
        end
        S_TICK_END: begin
          state <= S_DONE;
          if (at_end) begin
            if (loop_mode) begin
              playhead_r   <= rs_r;
              samples_left <= samples_left - 1'b1;
            end else begin
              playhead_r   <= head_inc[LEN_W-1:0];
              is_playing   <= 1'b0;
              samples_left <= '0;
            end
          end else begin
            playhead_r   <= head_inc[LEN_W-1:0];
            samples_left <= samples_left - 1'b1;
          end
        end
        S_DONE: begin
          if (!out_valid || result.ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Working values: region points, fetched frame and tick output
  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      audio_r <= '0;
    end
    if (state == S_TRIG_CAP || state == S_TICK_RE) begin
      rs_r <= region_pt;
    end
    if (state == S_TICK_RE) begin
      // Frames past the stored length read as silence
      sample_r <= head_ok ? $signed(ram_rdata) : '0;
    end
    if (state == S_TICK_GAIN) begin
      re_r <= region_pt;
    end
    if (state == S_TICK_END) begin
      audio_r <= gain_sat;
    end
  end

  // Output register: load when the finished result finds it free or draining
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && (!out_valid || result.ready)) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_valid || result.ready)) begin
      out_audio    <= audio_r;
      out_playing  <= is_playing;
      out_playhead <= playhead_r;
    end
  end

  // A playing voice always has a sample behind it
  `SPV_ASSERT_IMPLIES(a_play_has_sample, clk, rst, is_playing, frame_count != '0,
                      "voice playing with no stored sample")
  // The playhead never runs past one frame beyond the largest region end
  `SPV_ASSERT_IMPLIES(a_playhead_bound, clk, rst, 1'b1, playhead_r <= 17'd65537,
                      "playhead out of range")
  // A finished countdown division always arms the voice
  `SPV_ASSERT_NEXT(a_trigger_arms, clk, rst, state == S_TRIG_DIV && div_done, is_playing,
                   "trigger completed without starting playback")
  // An accepted command is decoded in the next cycle
  `SPV_ASSERT_NEXT(a_accept_decodes, clk, rst, item.valid && item.ready, state == S_DECODE,
                   "accepted command not decoded")

endmodule

/* dv/tb_sample_playback_voice_top.sv */
// ----------------------------------------------------------------------------
// Sampler voice testbench
// Drives load, clear, trigger, stop and tick commands into the voice, keeps a
// shadow copy of the sample store, length, playhead and countdown, and checks
// every returned sample against the value the shadow voice computes. Directed
// corner cases come first, then random phrases under changing register setups
// with random idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_sample_playback_voice_top;
  import spv_pkg::*;

  localparam int SB            = SAMPLE_BITS_DEFAULT;
  localparam int DEPTH         = STORE_DEPTH_DEFAULT;
  localparam int RESET_CYCLES  = 12;
  localparam int SETTLE_CYCLES = 16;
  localparam int BURST_MAX     = 15;
  localparam int RANDOM_ITEMS  = 600;
  localparam int RANDOM_PHASES = 8;
  localparam int TIMEOUT_NS    = 6_000_000;

  // Codes above tick carry no meaning; the voice must ignore them.
  localparam logic [OP_W-1:0] OP_UNUSED_LAST = 3'd7;

  // Countdown scale: beats in Q8.8, tempo in Q10.6, so 60 * 2^6 / 2^8.
  localparam longint unsigned COUNT_PER_BEAT = 15;

  typedef struct {
    logic [OP_W-1:0]        op;
    logic [ADDR_W-1:0]      addr;
    logic signed [SB-1:0]   value;
    logic                   last;
    logic [BEATS_W-1:0]     beats;
    logic [TEMPO_W-1:0]     tempo;
  } voice_cmd_t;

  typedef struct {
    logic signed [SB-1:0]   audio;
    logic                   playing;
    logic [LEN_W-1:0]       playhead;
  } voice_out_t;

  logic clk = 1'b0;
  logic rst;

  spv_item_if   #(.SAMPLE_BITS(SB)) item_ch ();
  spv_result_if #(.SAMPLE_BITS(SB)) result_ch ();
  spv_cfg_if                        cfg_ch ();

  sample_playback_voice_top #(
    .STORE_DEPTH (DEPTH),
    .SAMPLE_BITS (SB)
  ) i_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Shadow voice: store contents, which entries were ever loaded, control
  // state and register copies. Updated in command order as commands go out.
  // --------------------------------------------------------------------------
  logic signed [SB-1:0] shadow_frames [DEPTH];
  bit                   frame_written [DEPTH];
  int unsigned          sh_frame_count;
  int unsigned          sh_head;
  int unsigned          sh_left;
  bit                   sh_playing;

  int unsigned          sh_start_frac;
  int unsigned          sh_end_frac;
  int unsigned          sh_gain;
  bit                   sh_loop;
  int unsigned          sh_rate;

  voice_out_t           voice_out_q [$];
  int                   mismatch_count = 0;
  int                   items_sent = 0;

  // Idling knobs, in percent chance per transaction of starting a burst.
  int                   send_gap_pct = 25;
  int                   stall_pct = 25;

  // Frame index of a region edge for a Q0.16 fraction, clamped to 1.0.
  function automatic int unsigned region_edge(input int unsigned frac);
    longint unsigned f;
    f = (frac > FRAC_ONE) ? longint'(FRAC_ONE) : longint'(frac);
    return int'((longint'(sh_frame_count) * f) >> FRAC_SHIFT);
  endfunction

  // Q2.14 gain, round half up, saturate to the sample range.
  function automatic logic signed [SB-1:0] scale_frame(input logic signed [SB-1:0] s);
    longint g;
    longint p;
    longint q;
    longint hi;
    g  = (sh_gain > GAIN_MAX) ? longint'(GAIN_MAX) : longint'(sh_gain);
    p  = longint'(s) * g;
    q  = (p + (longint'(1) <<< (GAIN_SHIFT - 1))) >>> GAIN_SHIFT;
    hi = (longint'(1) <<< (SB - 1)) - 1;
    if (q > hi) q = hi;
    if (q < -hi - 1) q = -hi - 1;
    return SB'(q);
  endfunction

  // Apply one command to the shadow voice and return the output it yields.
  function automatic voice_out_t advance_voice(input voice_cmd_t c);
    voice_out_t           r;
    longint unsigned      n;
    int unsigned          rs;
    int unsigned          re;
    logic signed [SB-1:0] s;
    r.audio = '0;
    case (c.op)
      OP_LOAD: begin
        shadow_frames[c.addr] = c.value;
        frame_written[c.addr] = 1'b1;
        if (c.last) sh_frame_count = int'(c.addr) + 1;
      end
      OP_CLEAR: begin
        sh_frame_count = 0;
        sh_playing = 1'b0;
      end
      OP_TRIGGER: begin
        if (sh_frame_count != 0) begin
          if (c.tempo == 0) begin
            n = COUNT_MAX;
          end else begin
            n = (longint'(c.beats) * COUNT_PER_BEAT * longint'(sh_rate)) / c.tempo;
            if (n > COUNT_MAX) n = COUNT_MAX;
          end
          sh_head = region_edge(sh_start_frac);
          sh_left = int'(n);
          sh_playing = 1'b1;
        end
      end
      OP_STOP: begin
        sh_playing = 1'b0;
        sh_left = 0;
      end
      OP_TICK: begin
        if (sh_frame_count != 0 && sh_playing) begin
          if (sh_left == 0) begin
            sh_playing = 1'b0;
          end else begin
            rs = region_edge(sh_start_frac);
            re = region_edge(sh_end_frac);
            if (re <= rs) re = rs + 1;
            s = '0;
            if (sh_head < sh_frame_count) s = shadow_frames[sh_head];
            r.audio = scale_frame(s);
            sh_head++;
            if (sh_head >= re) begin
              if (sh_loop) begin
                sh_head = rs;
                sh_left--;
              end else begin
                sh_playing = 1'b0;
                sh_left = 0;
              end
            end else begin
              sh_left--;
            end
          end
        end
      end
      default: ;
    endcase
    r.playing  = sh_playing;
    r.playhead = LEN_W'(sh_head);
    return r;
  endfunction

  // True when the next tick would fetch a store entry never loaded.
  function automatic bit tick_reads_blank();
    return sh_playing && sh_frame_count != 0 && sh_left != 0 &&
           sh_head < sh_frame_count && !frame_written[sh_head];
  endfunction

  function automatic voice_cmd_t make_cmd(input logic [OP_W-1:0] op,
                                          input logic [ADDR_W-1:0] addr,
                                          input logic signed [SB-1:0] value,
                                          input logic last,
                                          input logic [BEATS_W-1:0] beats,
                                          input logic [TEMPO_W-1:0] tempo);
    voice_cmd_t c;
    c.op    = op;
    c.addr  = addr;
    c.value = value;
    c.last  = last;
    c.beats = beats;
    c.tempo = tempo;
    return c;
  endfunction

  // Any command with any fields; a length-setting load mostly stays short.
  function automatic voice_cmd_t random_cmd();
    voice_cmd_t c;
    c = make_cmd(OP_W'($urandom_range(0, OP_UNUSED_LAST)), ADDR_W'($urandom()),
                 SB'($urandom()), 1'($urandom_range(0, 1)), BEATS_W'($urandom()),
                 TEMPO_W'($urandom()));
    if (c.op == OP_LOAD && c.last && $urandom_range(0, 9) != 0)
      c.addr = ADDR_W'($urandom_range(0, 63));
    return c;
  endfunction

  // --------------------------------------------------------------------------
  // Command channel. Every task returns right after a rising edge, so the
  // next drive lands as a single nonblocking update in that step.
  // --------------------------------------------------------------------------
  task automatic push_item(input voice_cmd_t c);
    int gap;
    gap = 0;
    if (send_gap_pct > 0 && $urandom_range(0, 99) < send_gap_pct)
      gap = $urandom_range(1, BURST_MAX);
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    voice_out_q.push_back(advance_voice(c));
    item_ch.valid         <= 1'b1;
    item_ch.operation     <= c.op;
    item_ch.frame_address <= c.addr;
    item_ch.sample_value  <= c.value;
    item_ch.last_frame    <= c.last;
    item_ch.beat_duration <= c.beats;
    item_ch.tempo         <= c.tempo;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  // Fill the entry under the playhead first if a tick would read it blank.
  task automatic send_item(input voice_cmd_t c);
    if (c.op == OP_TICK && tick_reads_blank())
      push_item(make_cmd(OP_LOAD, ADDR_W'(sh_head), SB'($urandom()), 1'b0,
                         BEATS_W'($urandom()), TEMPO_W'($urandom())));
    push_item(c);
  endtask

  task automatic load_frame(input logic [ADDR_W-1:0] addr, input logic signed [SB-1:0] value,
                            input logic last);
    send_item(make_cmd(OP_LOAD, addr, value, last, '0, '0));
  endtask

  task automatic start_note(input logic [BEATS_W-1:0] beats, input logic [TEMPO_W-1:0] tempo);
    send_item(make_cmd(OP_TRIGGER, '0, '0, 1'b0, beats, tempo));
  endtask

  task automatic send_op(input logic [OP_W-1:0] op);
    send_item(make_cmd(op, '0, '0, 1'b0, '0, '0));
  endtask

  task automatic play_ticks(input int n);
    repeat (n) send_op(OP_TICK);
  endtask

  // Hold the command channel until every returned sample has been checked.
  task automatic wait_voice_idle();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (voice_out_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write; only called while the voice is idle.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    case (idx)
      REG_START_FRACTION: sh_start_frac = int'(data[FRAC_W-1:0]);
      REG_END_FRACTION:   sh_end_frac   = int'(data[FRAC_W-1:0]);
      REG_GAIN:           sh_gain       = int'(data[GAIN_W-1:0]);
      REG_LOOP_MODE:      sh_loop       = data[0];
      REG_SAMPLE_RATE:    sh_rate       = int'(data[RATE_W-1:0]);
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Register value: an edge of the legal range, a value inside it, or raw bits.
  function automatic logic [CFG_DATA_W-1:0] pick_setting(input int unsigned lo,
                                                          input int unsigned hi);
    case ($urandom_range(0, 6))
      0:       return CFG_DATA_W'(lo);
      1:       return CFG_DATA_W'(hi);
      2, 3:    return CFG_DATA_W'($urandom_range(lo, hi));
      4:       return CFG_DATA_W'($urandom());
      5:       return '1;
      default: return '0;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Directed tests
  // --------------------------------------------------------------------------

  // Idle tick, trigger with no sample, then a four-frame one-shot with the
  // sample extremes, running past the region end.
  task automatic test_oneshot_playback();
    play_ticks(1);
    start_note(16'h0100, 16'd7680);
    load_frame(16'd0, 16'sh7FFF, 1'b0);
    load_frame(16'd1, 16'sh8000, 1'b0);
    load_frame(16'd2, 16'sh0000, 1'b0);
    load_frame(16'd3, 16'sh0001, 1'b1);
    load_frame(16'hFFFF, 16'shFFFF, 1'b0);
    start_note(16'h0400, 16'd7680);
    play_ticks(5);
  endtask

  // Full 2.0 gain drives both sample extremes into saturation.
  task automatic test_gain_saturation();
    wait_voice_idle();
    write_reg(REG_GAIN, CFG_DATA_W'(GAIN_MAX));
    start_note(16'h0400, 16'd7680);
    play_ticks(2);
  endtask

  // Looping over a middle region, then a region squeezed to one frame past
  // the stored length, with both fractions above one.
  task automatic test_loop_region();
    wait_voice_idle();
    write_reg(REG_GAIN, CFG_DATA_W'(GAIN_ONE));
    write_reg(REG_START_FRACTION, 18'd16384);
    write_reg(REG_END_FRACTION, 18'd49152);
    write_reg(REG_LOOP_MODE, 18'd1);
    start_note(16'h0400, 16'd7680);
    play_ticks(3);
    send_op(OP_STOP);
    wait_voice_idle();
    write_reg(REG_START_FRACTION, 18'd98304);
    write_reg(REG_END_FRACTION, 18'd98304);
    start_note(16'h0400, 16'd7680);
    play_ticks(2);
  endtask

  // Zero-length countdown stops on the first tick; zero tempo saturates.
  task automatic test_countdown_edges();
    wait_voice_idle();
    write_reg(REG_START_FRACTION, 18'd0);
    write_reg(REG_END_FRACTION, CFG_DATA_W'(FRAC_ONE));
    start_note(16'h0000, 16'd7680);
    play_ticks(1);
    start_note(16'h0100, 16'h0000);
    play_ticks(1);
    send_op(OP_STOP);
  endtask

  // Unused code, clear during playback, trigger after clear, then the
  // longest sample: playhead walks off the last frame to the store depth.
  task automatic test_store_edges();
    start_note(16'h0100, 16'd7680);
    send_op(OP_UNUSED_LAST);
    send_op(OP_CLEAR);
    start_note(16'h0100, 16'd7680);
    wait_voice_idle();
    write_reg(REG_START_FRACTION, 18'd65535);
    write_reg(REG_LOOP_MODE, 18'd0);
    load_frame(16'hFFFF, -16'sd12345, 1'b1);
    start_note(16'h0100, 16'd7680);
    play_ticks(2);
    send_op(OP_CLEAR);
  endtask

  // --------------------------------------------------------------------------
  // Random traffic: phases under a fresh register setup, mostly well-formed
  // phrases (load a sample, trigger, tick) with noise commands mixed in.
  // --------------------------------------------------------------------------
  task automatic test_random_traffic();
    int phase_goal;
    int n;
    int k;
    logic [BEATS_W-1:0] beats;
    logic [TEMPO_W-1:0] tempo;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      // Drain before touching registers.
      wait_voice_idle();
      if (ph == 0) begin
        write_reg(REG_START_FRACTION, 18'd0);
        write_reg(REG_END_FRACTION, CFG_DATA_W'(FRAC_ONE));
        write_reg(REG_GAIN, CFG_DATA_W'(GAIN_MAX));
        write_reg(REG_LOOP_MODE, 18'd0);
        write_reg(REG_SAMPLE_RATE, 18'd192000);
      end else if (ph == 1) begin
        write_reg(REG_START_FRACTION, 18'd0);
        write_reg(REG_END_FRACTION, CFG_DATA_W'(FRAC_ONE));
        write_reg(REG_GAIN, 18'd0);
        write_reg(REG_LOOP_MODE, 18'd1);
        write_reg(REG_SAMPLE_RATE, 18'd1);
      end else begin
        // Keep the start low most of the time so regions have length.
        if ($urandom_range(0, 2) == 0)
          write_reg(REG_START_FRACTION, pick_setting(0, FRAC_ONE));
        else
          write_reg(REG_START_FRACTION, CFG_DATA_W'($urandom_range(0, 32768)));
        write_reg(REG_END_FRACTION, pick_setting(0, FRAC_ONE));
        write_reg(REG_GAIN, pick_setting(0, GAIN_MAX));
        write_reg(REG_LOOP_MODE, pick_setting(0, 1));
        write_reg(REG_SAMPLE_RATE, pick_setting(1, 192000));
      end

      // Last phase runs with no idling at all.
      if (ph == RANDOM_PHASES - 1) begin
        send_gap_pct = 0;
        stall_pct = 0;
      end else begin
        send_gap_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
        stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
      end

      phase_goal = items_sent + RANDOM_ITEMS / RANDOM_PHASES;
      while (items_sent < phase_goal) begin
        if ($urandom_range(0, 99) < 75) begin
          n = ($urandom_range(0, 29) == 0) ? $urandom_range(25, 120) : $urandom_range(1, 24);
          for (int i = 0; i < n; i++)
            load_frame(ADDR_W'(i),
                       ($urandom_range(0, 7) == 0) ?
                         (($urandom_range(0, 1) == 0) ? 16'sh7FFF : 16'sh8000) :
                         SB'($urandom()),
                       i == n - 1);
          case ($urandom_range(0, 3))
            0: begin
              beats = BEATS_W'($urandom());
              tempo = TEMPO_W'($urandom());
            end
            1: begin
              // Short countdown so it runs out mid-phrase.
              beats = BEATS_W'($urandom_range(0, 3));
              tempo = TEMPO_W'($urandom_range(16'h8000, 16'hFFFF));
            end
            2: begin
              beats = BEATS_W'($urandom());
              tempo = '0;
            end
            default: begin
              beats = BEATS_W'($urandom_range(1, 8) * 256);
              tempo = TEMPO_W'($urandom_range(60, 240) * 64);
            end
          endcase
          start_note(beats, tempo);
          k = $urandom_range(1, 2 * n + 6);
          if (k > 60) k = 60;
          for (int j = 0; j < k; j++) begin
            if ($urandom_range(0, 14) == 0) send_item(random_cmd());
            else play_ticks(1);
          end
        end else begin
          send_item(random_cmd());
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side: random back-pressure, and an in-order compare of every
  // returned transaction against the oldest predicted output.
  // --------------------------------------------------------------------------
  initial begin : result_check
    voice_out_t want;
    int         stall_left;
    stall_left = 0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_ch.valid && result_ch.ready) begin
        if (voice_out_q.size() == 0) begin
          $error("unexpected result: audio_out %0d playing %0b playhead %0d",
                 result_ch.audio_out, result_ch.playing, result_ch.playhead);
          mismatch_count++;
        end else begin
          want = voice_out_q.pop_front();
          if (result_ch.audio_out !== want.audio) begin
            $error("audio_out mismatch: expected %0d, actual %0d",
                   want.audio, result_ch.audio_out);
            mismatch_count++;
          end
          if (result_ch.playing !== want.playing) begin
            $error("playing mismatch: expected %0b, actual %0b",
                   want.playing, result_ch.playing);
            mismatch_count++;
          end
          if (result_ch.playhead !== want.playhead) begin
            $error("playhead mismatch: expected %0d, actual %0d",
                   want.playhead, result_ch.playhead);
            mismatch_count++;
          end
        end
      end
      // Drop ready for a burst now and then; one update per edge.
      if (stall_left > 0) begin
        result_ch.ready <= 1'b0;
        stall_left--;
      end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
        result_ch.ready <= 1'b0;
        stall_left = $urandom_range(0, BURST_MAX - 1);
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  // Hard stop in case the voice hangs.
  initial begin : watchdog
    #TIMEOUT_NS;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : main_sequence
    rst                   <= 1'b1;
    item_ch.valid         <= 1'b0;
    item_ch.operation     <= OP_LOAD;
    item_ch.frame_address <= '0;
    item_ch.sample_value  <= '0;
    item_ch.last_frame    <= 1'b0;
    item_ch.beat_duration <= '0;
    item_ch.tempo         <= '0;
    cfg_ch.valid          <= 1'b0;
    cfg_ch.index          <= REG_START_FRACTION;
    cfg_ch.data           <= '0;

    // Shadow voice starts from the reset register values.
    sh_frame_count = 0;
    sh_head        = 0;
    sh_left        = 0;
    sh_playing     = 1'b0;
    sh_start_frac  = 0;
    sh_end_frac    = FRAC_ONE;
    sh_gain        = GAIN_ONE;
    sh_loop        = 1'b0;
    sh_rate        = RATE_RESET;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_oneshot_playback();
    test_gain_saturation();
    test_loop_region();
    test_countdown_edges();
    test_store_edges();
    test_random_traffic();

    // Wait out every outstanding result plus a settle window.
    wait_voice_idle();
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+sv
sv/spv_pkg.sv
sv/spv_if.sv
sv/spv_ram.sv
sv/spv_alu.sv
sv/sample_playback_voice_top.sv
dv/tb_sample_playback_voice_top.sv
